### rtl/core/spq_pkg.sv
// Package with the shared types and constants of the stable priority queue table.
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int PRIO_W = 31;
  localparam int ENTRY_W = DATA_W + PRIO_W;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPRIO  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        priority_val;
  } entry_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] in_data;
    logic [PRIO_W-1:0]        in_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;
    status_t                  status;
    logic                     last;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/spq_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/stable_priority_queue_table_top.sv
// Top level of the stable priority queue table: command sequencer around the entry memory.
// List reads each entry in S_LIST_RD and hands it out in S_LIST_OUT, which waits while the output is full.
// One command is worked on at a time; the next is taken while the last result waits.
// Synchronous reset empties the table at once; the memory itself is not cleared.
`default_nettype none
module stable_priority_queue_table_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire spq_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spq_pkg::out_item_t       out_item
);

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_CHK, S_PUSH_INS, S_LIST_RD, S_LIST_OUT,
    S_DEL_RD, S_DEL_CHK
  } state_t;

  state_t                        state;
  logic                          resp_pending;
  spq_pkg::status_t              resp_status;
  logic [spq_pkg::CNT_W-1:0]     count;
  logic [spq_pkg::CNT_W-1:0]     idx;
  logic [spq_pkg::CNT_W-1:0]     wr;
  logic                          hit;
  logic signed [spq_pkg::DATA_W-1:0] key_data;
  logic [spq_pkg::PRIO_W-1:0]    key_prio;

  logic                          we;
  logic [spq_pkg::IDX_W-1:0]     waddr;
  spq_pkg::entry_t               wdata;
  logic                          re;
  logic [spq_pkg::IDX_W-1:0]     raddr;
  spq_pkg::entry_t               rdata;
  logic                          out_free;
  logic                          out_load;
  logic                          match;

  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (resp_pending || (state == S_LIST_OUT));
  assign in_ready = (state == S_IDLE) && !resp_pending;
  assign match = (rdata.data == key_data) && (rdata.priority_val == key_prio);

  always_comb begin
    we = 1'b0;
    waddr = idx[spq_pkg::IDX_W-1:0];
    wdata = rdata;
    re = 1'b0;
    raddr = idx[spq_pkg::IDX_W-1:0];
    case (state)
      S_PUSH_RD: begin
        re = 1'b1;
        raddr = spq_pkg::IDX_W'(idx - 1'b1);
      end
      S_PUSH_CHK: begin
        we = (rdata.priority_val < key_prio);
      end
      S_PUSH_INS: begin
        we = 1'b1;
        wdata.data = key_data;
        wdata.priority_val = key_prio;
      end
      S_LIST_RD, S_DEL_RD: begin
        re = 1'b1;
      end
      S_DEL_CHK: begin
        we = !match;
        waddr = wr[spq_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  spq_ram #(
    .WIDTH(spq_pkg::ENTRY_W),
    .WORDS(spq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resp_pending <= 1'b0;
      resp_status <= spq_pkg::ST_OK;
      count <= '0;
      idx <= '0;
      wr <= '0;
      hit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (resp_pending && out_free) begin
        out_valid <= 1'b1;
        out_item.out_data <= '0;
        out_item.out_priority <= '0;
        out_item.status <= resp_status;
        out_item.last <= 1'b1;
        out_item.entry_count <= spq_pkg::COUNT_FIELD_W'(count);
        resp_pending <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            key_data <= in_item.in_data;
            key_prio <= in_item.in_priority;
            case (in_item.cmd)
              spq_pkg::CMD_PUSH: begin
                if (in_item.in_priority == '0) begin
                  resp_status <= spq_pkg::ST_BADPRIO;
                  resp_pending <= 1'b1;
                end else if (count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                  resp_status <= spq_pkg::ST_FULL;
                  resp_pending <= 1'b1;
                end else begin
                  idx <= count;
                  state <= (count == '0) ? S_PUSH_INS : S_PUSH_RD;
                end
              end
              spq_pkg::CMD_LIST: begin
                if (count == '0) begin
                  resp_status <= spq_pkg::ST_EMPTY;
                  resp_pending <= 1'b1;
                end else begin
                  idx <= '0;
                  state <= S_LIST_RD;
                end
              end
              spq_pkg::CMD_DELETE: begin
                if (count == '0) begin
                  resp_status <= spq_pkg::ST_EMPTY;
                  resp_pending <= 1'b1;
                end else begin
                  idx <= '0;
                  wr <= '0;
                  hit <= 1'b0;
                  state <= S_DEL_RD;
                end
              end
              spq_pkg::CMD_CLEAR: begin
                count <= '0;
                resp_status <= spq_pkg::ST_OK;
                resp_pending <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH_RD: begin
          state <= S_PUSH_CHK;
        end
        S_PUSH_CHK: begin
          if (rdata.priority_val >= key_prio) begin
            state <= S_PUSH_INS;
          end else begin
            idx <= idx - 1'b1;
            state <= (idx == spq_pkg::CNT_W'(1)) ? S_PUSH_INS : S_PUSH_RD;
          end
        end
        S_PUSH_INS: begin
          count <= count + 1'b1;
          resp_status <= spq_pkg::ST_OK;
          resp_pending <= 1'b1;
          state <= S_IDLE;
        end
        S_LIST_RD: begin
          state <= S_LIST_OUT;
        end
        S_LIST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item.out_data <= rdata.data;
            out_item.out_priority <= rdata.priority_val;
            out_item.status <= spq_pkg::ST_OK;
            out_item.last <= (idx + 1'b1 == count);
            out_item.entry_count <= spq_pkg::COUNT_FIELD_W'(count);
            idx <= idx + 1'b1;
            state <= (idx + 1'b1 == count) ? S_IDLE : S_LIST_RD;
          end
        end
        S_DEL_RD: begin
          state <= S_DEL_CHK;
        end
        S_DEL_CHK: begin
          idx <= idx + 1'b1;
          if (match) begin
            hit <= 1'b1;
          end else begin
            wr <= wr + 1'b1;
          end
          if (idx + 1'b1 == count) begin
            count <= match ? wr : wr + 1'b1;
            resp_status <= (hit || match) ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
            resp_pending <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DEL_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_item.cmd == spq_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("Clear did not empty the table.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != spq_pkg::ST_OK) |-> out_item.last)
    else $error("An error result was not the last item of its command.");

  a_listed_prio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == spq_pkg::ST_OK && !out_item.last)
      |-> (out_item.out_priority != '0))
    else $error("A listed entry carries a zero priority.");

endmodule
`default_nettype wire

### test/testbench.sv
// Testbench for the stable priority queue table: directed table, random commands, scoreboard.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  spq_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spq_pkg::out_item_t out_item;

  stable_priority_queue_table_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #10 clk = ~clk;

  logic signed [spq_pkg::DATA_W-1:0] tbl_data [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0] tbl_prio [spq_pkg::DEPTH];
  int tbl_count = 0;
  spq_pkg::out_item_t pending_results[$];
  int errors = 0;
  bit sender_idle_off = 0;
  bit receiver_idle_off = 0;
  int hold_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("Mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic spq_pkg::out_item_t mk(input logic signed [spq_pkg::DATA_W-1:0] d,
                                            input logic [spq_pkg::PRIO_W-1:0] p,
                                            input spq_pkg::status_t s,
                                            input logic l);
    spq_pkg::out_item_t r;
    r.out_data = d;
    r.out_priority = p;
    r.status = s;
    r.last = l;
    r.entry_count = spq_pkg::COUNT_FIELD_W'(tbl_count);
    return r;
  endfunction

  task automatic predict_queue(input spq_pkg::in_item_t it);
    int pos;
    int wr;
    bit hit;
    spq_pkg::status_t s;
    case (it.cmd)
      spq_pkg::CMD_PUSH: begin
        if (it.in_priority == 0) s = spq_pkg::ST_BADPRIO;
        else if (tbl_count >= spq_pkg::DEPTH) s = spq_pkg::ST_FULL;
        else begin
          pos = 0;
          while (pos < tbl_count && tbl_prio[pos] >= it.in_priority) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_data[i] = tbl_data[i-1];
            tbl_prio[i] = tbl_prio[i-1];
          end
          tbl_data[pos] = it.in_data;
          tbl_prio[pos] = it.in_priority;
          tbl_count++;
          s = spq_pkg::ST_OK;
        end
        pending_results.push_back(mk(0, 0, s, 1'b1));
      end
      spq_pkg::CMD_LIST: begin
        if (tbl_count == 0) pending_results.push_back(mk(0, 0, spq_pkg::ST_EMPTY, 1'b1));
        for (int i = 0; i < tbl_count; i++)
          pending_results.push_back(mk(tbl_data[i], tbl_prio[i], spq_pkg::ST_OK,
                                       i + 1 == tbl_count));
      end
      spq_pkg::CMD_DELETE: begin
        if (tbl_count == 0) s = spq_pkg::ST_EMPTY;
        else begin
          wr = 0;
          hit = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_data[i] == it.in_data && tbl_prio[i] == it.in_priority) hit = 1;
            else begin
              tbl_data[wr] = tbl_data[i];
              tbl_prio[wr] = tbl_prio[i];
              wr++;
            end
          end
          tbl_count = wr;
          s = hit ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
        end
        pending_results.push_back(mk(0, 0, s, 1'b1));
      end
      default: begin
        tbl_count = 0;
        pending_results.push_back(mk(0, 0, spq_pkg::ST_OK, 1'b1));
      end
    endcase
  endtask

  task automatic send(input spq_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    if (!sender_idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_queue(it);
  endtask

  function automatic spq_pkg::in_item_t cmd_item(input spq_pkg::cmd_t c,
                                                 input logic signed [spq_pkg::DATA_W-1:0] d,
                                                 input logic [spq_pkg::PRIO_W-1:0] p);
    spq_pkg::in_item_t it;
    it.cmd = c;
    it.in_data = d;
    it.in_priority = p;
    return it;
  endfunction

  function automatic spq_pkg::status_t predict_status(input spq_pkg::in_item_t it);
    if (it.cmd == spq_pkg::CMD_CLEAR) return spq_pkg::ST_OK;
    if (it.cmd == spq_pkg::CMD_LIST)
      return (tbl_count == 0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
    if (it.cmd == spq_pkg::CMD_PUSH) begin
      if (it.in_priority == 0) return spq_pkg::ST_BADPRIO;
      return (tbl_count >= spq_pkg::DEPTH) ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
    end
    if (tbl_count == 0) return spq_pkg::ST_EMPTY;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_data[i] == it.in_data && tbl_prio[i] == it.in_priority) return spq_pkg::ST_OK;
    return spq_pkg::ST_NOTFOUND;
  endfunction

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (!receiver_idle_off && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      hold_cycles = $urandom_range(0, 8);
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    spq_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) report_mismatch("result with none expected");
      else begin
        exp_r = pending_results.pop_front();
        if (out_item.out_data !== exp_r.out_data) report_mismatch("out_data");
        if (out_item.out_priority !== exp_r.out_priority) report_mismatch("out_priority");
        if (out_item.status !== exp_r.status) report_mismatch("status");
        if (out_item.last !== exp_r.last) report_mismatch("last");
        if (out_item.entry_count !== exp_r.entry_count) report_mismatch("entry_count");
      end
    end
  end

  // Directed rows: checks with a known answer are typed in; the rest use the predictor.
  typedef struct {
    spq_pkg::in_item_t it;
    bit has_fixed;
    spq_pkg::status_t st;
  } row_t;

  initial begin
    row_t rows[$];
    spq_pkg::in_item_t it;
    logic [spq_pkg::PRIO_W-1:0] pr;
    logic signed [spq_pkg::DATA_W-1:0] dv;
    int kind;
    rows.push_back('{cmd_item(spq_pkg::CMD_LIST, 0, 0), 1, spq_pkg::ST_EMPTY});
    rows.push_back('{cmd_item(spq_pkg::CMD_DELETE, 5, 5), 1, spq_pkg::ST_EMPTY});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, 7, 0), 1, spq_pkg::ST_BADPRIO});
    rows.push_back('{cmd_item(spq_pkg::CMD_CLEAR, 0, 0), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, 32'sh7fffffff, 31'h7fffffff), 1,
                     spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, 32'sh80000000, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, -1, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, 3, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, 3, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_LIST, 0, 0), 0, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_DELETE, 3, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_DELETE, 3, 1), 1, spq_pkg::ST_NOTFOUND});
    rows.push_back('{cmd_item(spq_pkg::CMD_DELETE, 32'sh7fffffff, 31'h7fffffff), 1,
                     spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_DELETE, -1, 1), 1, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_LIST, 0, 0), 0, spq_pkg::ST_OK});
    for (int i = 0; i < spq_pkg::DEPTH; i++)
      rows.push_back('{cmd_item(spq_pkg::CMD_PUSH, i, 31'(i % 3 + 1)), 0, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_LIST, 0, 0), 0, spq_pkg::ST_OK});
    rows.push_back('{cmd_item(spq_pkg::CMD_CLEAR, 0, 0), 1, spq_pkg::ST_OK});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].has_fixed && rows[i].st != predict_status(rows[i].it))
        report_mismatch("directed row disagrees with predictor");
      send(rows[i].it);
    end

    // Fill the table and overflow it while the receiver holds off.
    hold_cycles = 200;
    for (int i = 0; i < spq_pkg::DEPTH + 2; i++)
      send(cmd_item(spq_pkg::CMD_PUSH, $urandom, 31'($urandom_range(1, 4))));
    send(cmd_item(spq_pkg::CMD_LIST, 0, 0));

    for (int n = 0; n < 300; n++) begin
      if (n == 250) begin
        sender_idle_off = 1;
        receiver_idle_off = 1;
      end
      kind = $urandom_range(0, 99);
      pr = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6));
      dv = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 7);
      if (kind < 50) it = cmd_item(spq_pkg::CMD_PUSH, dv, pr);
      else if (kind < 70) it = cmd_item(spq_pkg::CMD_LIST, $urandom, 31'($urandom));
      else if (kind < 95) it = cmd_item(spq_pkg::CMD_DELETE, dv, pr);
      else it = cmd_item(spq_pkg::CMD_CLEAR, $urandom, 31'($urandom));
      send(it);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
